// ===== rtl/pose_position_velocity_filter_top_macros.svh =====
// Assertion macros used by the estimator controller (ppvf_ctrl).
`ifndef POSE_POSITION_VELOCITY_FILTER_TOP_MACROS_SVH
`define POSE_POSITION_VELOCITY_FILTER_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PPVF_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ppvf: property failed");

// Next-cycle implication.
`define PPVF_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ppvf: property failed");

`endif

// ===== rtl/ppvf_pkg.sv =====
`default_nettype none
package ppvf_pkg;

	localparam int TABLE_FRAC = 40;
	localparam int US_PER_S = 1000000;

	localparam logic [63:0] T40 = 64'd1 << 40;
	localparam logic [63:0] E1 = 64'd10000000;
	localparam logic [63:0] E2 = 64'd100000000;
	localparam logic [63:0] E3 = 64'd1000000000;
	localparam logic [63:0] E4 = 64'd10000000000;
	localparam logic [63:0] E5 = 64'd100000000000;
	localparam logic [63:0] E6 = 64'd1000000000000;
	localparam logic [63:0] E7 = 64'd10000000000000;

	// Position filter, rows are next state 0, next state 1, output; the last
	// term of each row is the input coefficient. 40 fraction bits.
	localparam logic signed [47:0] POS_COEF [9] = '{
		48'((64'd8710534 * T40 + E1 / 2) / E1),
		-48'((64'd8823664 * T40 + E2 / 2) / E2),
		48'((64'd1247855 * T40 + E1 / 2) / E1),
		48'((64'd8823664 * T40 + E2 / 2) / E2),
		48'((64'd9958389 * T40 + E1 / 2) / E1),
		48'((64'd5884733 * T40 + E3 / 2) / E3),
		48'((64'd3119636 * T40 + E2 / 2) / E2),
		48'((64'd7056356 * T40 + E1 / 2) / E1),
		48'((64'd2080567 * T40 + E3 / 2) / E3)
	};

	// Velocity filter, six rows of six terms in the same arrangement.
	localparam logic signed [47:0] VEL_COEF [36] = '{
		48'((64'd9099300 * T40 + E1 / 2) / E1), 48'sd0, 48'sd0, 48'sd0, 48'sd0,
		48'((64'd1273782 * T40 + E1 / 2) / E1),
		48'((64'd8351194 * T40 + E2 / 2) / E2),
		48'((64'd8543784 * T40 + E1 / 2) / E1),
		-48'((64'd8745027 * T40 + E2 / 2) / E2), 48'sd0, 48'sd0,
		48'((64'd5569630 * T40 + E3 / 2) / E3),
		48'((64'd3938323 * T40 + E3 / 2) / E3),
		48'((64'd8745027 * T40 + E2 / 2) / E2),
		48'((64'd9958760 * T40 + E1 / 2) / E1), 48'sd0, 48'sd0,
		48'((64'd2626571 * T40 + E4 / 2) / E4),
		48'((64'd1800776 * T40 + E4 / 2) / E4),
		48'((64'd3998615 * T40 + E3 / 2) / E3),
		48'((64'd9126031 * T40 + E2 / 2) / E2),
		48'((64'd9391689 * T40 + E1 / 2) / E1),
		-48'((64'd9144888 * T40 + E2 / 2) / E2),
		48'((64'd1200985 * T40 + E5 / 2) / E5),
		48'((64'd8492246 * T40 + E6 / 2) / E6),
		48'((64'd1885699 * T40 + E4 / 2) / E4),
		48'((64'd4303727 * T40 + E3 / 2) / E3),
		48'((64'd9144888 * T40 + E2 / 2) / E2),
		48'((64'd9956874 * T40 + E1 / 2) / E1),
		48'((64'd5663701 * T40 + E7 / 2) / E7),
		48'((64'd3002462 * T40 + E6 / 2) / E6),
		48'((64'd6666952 * T40 + E5 / 2) / E5),
		48'((64'd1521597 * T40 + E3 / 2) / E3),
		48'((64'd3233206 * T40 + E2 / 2) / E2),
		48'((64'd7055820 * T40 + E1 / 2) / E1),
		48'((64'd2002421 * T40 + E7 / 2) / E7)
	};

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_FIRST,
		OP_START,
		OP_MAC,
		OP_STORE,
		OP_COMMIT_POS,
		OP_DIFF,
		OP_SCALE,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_USET,
		OP_COMMIT_VEL,
		OP_FINISH,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] axis;
		logic       vel;
		logic [2:0] row;
		logic [2:0] term;
		logic       half;
		logic       first;
	} dp_cmd_t;

	typedef struct packed {
		logic ok;
		logic seen;
	} dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/ppvf_dp.sv =====
`default_nettype none
module ppvf_dp import ppvf_pkg::*; #(
	parameter int COEF_FRAC_BITS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [39:0]        sample_time_us,
	input  wire logic signed [31:0] raw_pos_x,
	input  wire logic signed [31:0] raw_pos_y,
	input  wire logic signed [31:0] raw_pos_z,
	input  wire logic signed [15:0] quat_w,
	input  wire logic signed [15:0] quat_x,
	input  wire logic signed [15:0] quat_y,
	input  wire logic signed [15:0] quat_z,
	input  wire dp_cmd_t            cmd,
	output dp_status_t              status,
	output logic                    accepted,
	output logic signed [31:0]      filt_pos_x,
	output logic signed [31:0]      filt_pos_y,
	output logic signed [31:0]      filt_pos_z,
	output logic signed [31:0]      filt_vel_x,
	output logic signed [31:0]      filt_vel_y,
	output logic signed [31:0]      filt_vel_z
);

	localparam int CW = COEF_FRAC_BITS + 2;
	localparam int AW = COEF_FRAC_BITS + 52;
	localparam int SH = TABLE_FRAC - COEF_FRAC_BITS;
	localparam int SHM = (SH > 0) ? SH - 1 : 0;
	localparam logic signed [47:0] CRND = (SH > 0) ? (48'sd1 <<< SHM) : 48'sd0;
	localparam logic signed [AW-1:0] RHALF = AW'(1) << (COEF_FRAC_BITS - 1);

	// Filter state and history
	logic signed [47:0] pos_st_q [6];
	logic signed [47:0] vel_st_q [15];
	logic signed [31:0] prev_pos_q [3];
	logic signed [31:0] prev_vel_q [3];
	logic [39:0]        prev_time_q;
	logic               seen_q;

	// Sample and working registers
	logic [39:0]        time_q;
	logic signed [31:0] raw_q [3];
	logic               ok_q;
	logic signed [CW+24:0] prod_s1;
	logic               half_s1;
	logic               first_s1;
	logic               mac_s1;
	logic signed [AW-1:0] acc_q;
	logic signed [47:0] nx_q [5];
	logic signed [31:0] fp_q;
	logic signed [31:0] vy_q;
	logic signed [31:0] u_q;
	logic [39:0]        dt_q;
	logic               step_ok_q;
	logic signed [32:0] diff_q;
	logic [52:0]        dnum_q;
	logic               neg_q;
	logic               ovf_q;
	logic [39:0]        rem_q;
	logic [31:0]        quo_q;

	logic [3:0]         pidx;
	logic [5:0]         vidx;
	logic [2:0]         nmax;
	logic [2:0]         vterm;
	logic signed [47:0] q40;
	logic signed [47:0] cshift;
	logic signed [CW-1:0] coef_w;
	logic signed [47:0] x48;
	logic signed [24:0] opnd;
	logic signed [CW+24:0] prod;
	logic signed [AW-1:0] pext;
	logic signed [AW-1:0] addend;
	logic signed [AW-1:0] rsum;
	logic signed [51:0] rsh;
	logic signed [47:0] sat48;
	logic signed [31:0] sat32;
	logic [32:0]        mag;
	logic [40:0]        trial;
	logic               ge;

	assign status.ok   = ok_q;
	assign status.seen = seen_q;

	assign nmax  = cmd.vel ? 3'd5 : 3'd2;
	assign pidx  = 4'(cmd.row) * 4'd3 + 4'(cmd.term);
	assign vidx  = 6'(cmd.row) * 6'd6 + 6'(cmd.term);
	assign vterm = (cmd.term > 3'd4) ? 3'd4 : cmd.term;

	// Coefficient rounded from the table's 40 fraction bits to the working fraction.
	always_comb begin
		q40    = cmd.vel ? VEL_COEF[vidx] : POS_COEF[pidx];
		cshift = (q40 + CRND) >>> SH;
		coef_w = cshift[CW-1:0];
	end

	always_comb begin
		if (cmd.term == nmax) begin
			x48 = cmd.vel ? 48'(u_q) : 48'(raw_q[cmd.axis]);
		end else if (cmd.vel) begin
			x48 = vel_st_q[4'(cmd.axis) * 4'd5 + 4'(vterm)];
		end else begin
			x48 = pos_st_q[{cmd.axis, cmd.term[0]}];
		end
		// The 48-bit operand goes through the multiplier in two halves.
		opnd   = cmd.half ? $signed({x48[47], x48[47:24]}) : $signed({1'b0, x48[23:0]});
		prod   = coef_w * opnd;
		pext   = AW'(prod_s1);
		addend = half_s1 ? (pext <<< 24) : pext;
	end

	always_comb begin
		rsum = acc_q + RHALF;
		rsh  = rsum[AW-1:COEF_FRAC_BITS];
		if (&rsh[51:47] || ~|rsh[51:47]) begin
			sat48 = rsh[47:0];
		end else begin
			sat48 = rsh[51] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		end
		if (&rsh[51:31] || ~|rsh[51:31]) begin
			sat32 = rsh[31:0];
		end else begin
			sat32 = rsh[51] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
		end
		mag   = diff_q[32] ? 33'(-diff_q) : 33'(diff_q);
		trial = {rem_q, dnum_q[31]};
		ge    = trial >= {1'b0, dt_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) pos_st_q[i] <= '0;
			for (int i = 0; i < 15; i++) vel_st_q[i] <= '0;
			for (int i = 0; i < 3; i++) begin
				prev_pos_q[i] <= '0;
				prev_vel_q[i] <= '0;
			end
			prev_time_q <= '0;
			seen_q      <= 1'b0;
			mac_s1      <= 1'b0;
		end else begin
			mac_s1 <= (cmd.op == OP_MAC);
			unique case (cmd.op)
				OP_FIRST: begin
					for (int i = 0; i < 3; i++) begin
						prev_pos_q[i] <= raw_q[i];
						prev_vel_q[i] <= '0;
					end
					prev_time_q <= time_q;
					seen_q      <= 1'b1;
				end
				OP_COMMIT_POS: begin
					pos_st_q[{cmd.axis, 1'b0}] <= nx_q[0];
					pos_st_q[{cmd.axis, 1'b1}] <= nx_q[1];
				end
				OP_COMMIT_VEL: begin
					for (int k = 0; k < 5; k++) begin
						vel_st_q[4'(cmd.axis) * 4'd5 + 4'(k)] <= nx_q[k];
					end
					prev_vel_q[cmd.axis] <= vy_q;
					prev_pos_q[cmd.axis] <= fp_q;
				end
				OP_FINISH: prev_time_q <= time_q;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= prod;
		half_s1  <= cmd.half;
		first_s1 <= cmd.first;
		if (mac_s1) begin
			acc_q <= first_s1 ? addend : acc_q + addend;
		end
		unique case (cmd.op)
			OP_LOAD: begin
				time_q   <= sample_time_us;
				raw_q[0] <= raw_pos_x;
				raw_q[1] <= raw_pos_y;
				raw_q[2] <= raw_pos_z;
				ok_q     <= |{quat_w, quat_x, quat_y, quat_z};
			end
			OP_START: begin
				dt_q      <= time_q - prev_time_q;
				step_ok_q <= time_q > prev_time_q;
			end
			OP_STORE: begin
				if (cmd.row == nmax) begin
					if (cmd.vel) vy_q <= sat32;
					else fp_q <= sat32;
				end else begin
					nx_q[cmd.row] <= sat48;
				end
			end
			OP_DIFF: diff_q <= {fp_q[31], fp_q} - {prev_pos_q[cmd.axis][31], prev_pos_q[cmd.axis]};
			OP_SCALE: begin
				dnum_q <= 53'(mag) * 53'(US_PER_S);
				neg_q  <= diff_q[32];
			end
			OP_DIV_INIT: begin
				// A quotient of 2^32 or more is known from the top bits alone.
				ovf_q <= {19'd0, dnum_q[52:32]} >= dt_q;
				rem_q <= {19'd0, dnum_q[52:32]};
			end
			OP_DIV_STEP: begin
				rem_q        <= ge ? 40'(trial - {1'b0, dt_q}) : trial[39:0];
				dnum_q[31:0] <= {dnum_q[30:0], 1'b0};
				quo_q        <= {quo_q[30:0], ge};
			end
			OP_USET: begin
				if (!step_ok_q) begin
					u_q <= prev_vel_q[cmd.axis];
				end else if (neg_q) begin
					u_q <= (ovf_q || quo_q[31]) ? {1'b1, 31'd0} : -$signed(quo_q);
				end else begin
					u_q <= (ovf_q || quo_q[31]) ? {1'b0, {31{1'b1}}} : $signed(quo_q);
				end
			end
			OP_OUT: begin
				accepted   <= ok_q;
				filt_pos_x <= prev_pos_q[0];
				filt_pos_y <= prev_pos_q[1];
				filt_pos_z <= prev_pos_q[2];
				filt_vel_x <= prev_vel_q[0];
				filt_vel_y <= prev_vel_q[1];
				filt_vel_z <= prev_vel_q[2];
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/ppvf_ctrl.sv =====
`default_nettype none
`include "pose_position_velocity_filter_top_macros.svh"
module ppvf_ctrl import ppvf_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  wire logic       out_stall,
	input  wire dp_status_t status,
	output dp_cmd_t         cmd
);

	typedef enum logic [15:0] {
		S_IDLE   = 16'b0000_0000_0000_0001,
		S_DECIDE = 16'b0000_0000_0000_0010,
		S_FIRST  = 16'b0000_0000_0000_0100,
		S_START  = 16'b0000_0000_0000_1000,
		S_MAC    = 16'b0000_0000_0001_0000,
		S_WAIT   = 16'b0000_0000_0010_0000,
		S_STORE  = 16'b0000_0000_0100_0000,
		S_CPOS   = 16'b0000_0000_1000_0000,
		S_DIFF   = 16'b0000_0001_0000_0000,
		S_SCALE  = 16'b0000_0010_0000_0000,
		S_DINIT  = 16'b0000_0100_0000_0000,
		S_DSTEP  = 16'b0000_1000_0000_0000,
		S_USET   = 16'b0001_0000_0000_0000,
		S_CVEL   = 16'b0010_0000_0000_0000,
		S_FINISH = 16'b0100_0000_0000_0000,
		S_OUT    = 16'b1000_0000_0000_0000
	} state_t;

	state_t     state_q;
	logic [1:0] axis_q;
	logic       vel_q;
	logic [2:0] row_q;
	logic [2:0] term_q;
	logic       half_q;
	logic [4:0] cnt_q;
	logic       out_valid_q;
	logic [2:0] nmax;
	logic       slot_free;

	assign nmax      = vel_q ? 3'd5 : 3'd2;
	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.axis  = axis_q;
		cmd.vel   = vel_q;
		cmd.row   = row_q;
		cmd.term  = term_q;
		cmd.half  = half_q;
		cmd.first = (term_q == 3'd0) && !half_q;
		unique case (state_q)
			S_IDLE:   cmd.op = in_valid ? OP_LOAD : OP_NONE;
			S_FIRST:  cmd.op = OP_FIRST;
			S_START:  cmd.op = OP_START;
			S_MAC:    cmd.op = OP_MAC;
			S_STORE:  cmd.op = OP_STORE;
			S_CPOS:   cmd.op = OP_COMMIT_POS;
			S_DIFF:   cmd.op = OP_DIFF;
			S_SCALE:  cmd.op = OP_SCALE;
			S_DINIT:  cmd.op = OP_DIV_INIT;
			S_DSTEP:  cmd.op = OP_DIV_STEP;
			S_USET:   cmd.op = OP_USET;
			S_CVEL:   cmd.op = OP_COMMIT_VEL;
			S_FINISH: cmd.op = OP_FINISH;
			S_OUT:    cmd.op = slot_free ? OP_OUT : OP_NONE;
			default:  cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= '0;
			vel_q       <= 1'b0;
			row_q       <= '0;
			term_q      <= '0;
			half_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_DECIDE;
				S_DECIDE: begin
					if (!status.ok) state_q <= S_OUT;
					else if (!status.seen) state_q <= S_FIRST;
					else state_q <= S_START;
				end
				S_FIRST: state_q <= S_OUT;
				S_START: begin
					axis_q  <= '0;
					vel_q   <= 1'b0;
					row_q   <= '0;
					term_q  <= '0;
					half_q  <= 1'b0;
					state_q <= S_MAC;
				end
				S_MAC: begin
					half_q <= ~half_q;
					if (half_q) begin
						if (term_q == nmax) begin
							term_q  <= '0;
							state_q <= S_WAIT;
						end else begin
							term_q <= term_q + 3'd1;
						end
					end
				end
				// The last product still has to reach the accumulator.
				S_WAIT: state_q <= S_STORE;
				S_STORE: begin
					if (row_q == nmax) begin
						row_q   <= '0;
						state_q <= vel_q ? S_CVEL : S_CPOS;
					end else begin
						row_q   <= row_q + 3'd1;
						state_q <= S_MAC;
					end
				end
				S_CPOS:  state_q <= S_DIFF;
				S_DIFF:  state_q <= S_SCALE;
				S_SCALE: begin
					cnt_q   <= '0;
					state_q <= S_DINIT;
				end
				S_DINIT: state_q <= S_DSTEP;
				S_DSTEP: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) state_q <= S_USET;
				end
				S_USET: begin
					vel_q   <= 1'b1;
					state_q <= S_MAC;
				end
				S_CVEL: begin
					vel_q <= 1'b0;
					if (axis_q == 2'd2) begin
						state_q <= S_FINISH;
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= S_MAC;
					end
				end
				S_FINISH: state_q <= S_OUT;
				S_OUT: if (slot_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`PPVF_ASSERT_NEXT(a_accept_decide, in_valid && !in_stall, state_q == S_DECIDE)
	`PPVF_ASSERT_NEXT(a_div_length, state_q == S_DSTEP && cnt_q == 5'd31, state_q == S_USET)
	`PPVF_ASSERT_IMPL(a_out_slot_free, cmd.op == OP_OUT, !out_valid_q || !out_stall)

endmodule
`default_nettype wire

// ===== rtl/pose_position_velocity_filter_top.sv =====
// Channel  Handshake              Fields
// in       in_valid / in_stall    sample_time_us, raw_pos_x/y/z, quat_w/x/y/z
// out      out_valid / out_stall  accepted, filt_pos_x/y/z, filt_vel_x/y/z
//
// A sample with an all-zero quaternion goes straight to the output; the first valid one
// seeds the history from itself. Every later valid sample runs, per axis, the position filter,
// the commit, the difference and the bit-serial velocity divider, then the velocity
// filter and its commit, all on one shared coefficient multiplier fed one 24-bit half of
// the operand each cycle.
// Reset clears all filter state at once; there is no clearing pass.
// A new item is taken only in the idle state; a result waiting on out_stall holds
// the next item's completion, not its acceptance.
`default_nettype none
module pose_position_velocity_filter_top import ppvf_pkg::*; #(
	parameter int COEF_FRAC_BITS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [39:0]        sample_time_us,
	input  wire logic signed [31:0] raw_pos_x,
	input  wire logic signed [31:0] raw_pos_y,
	input  wire logic signed [31:0] raw_pos_z,
	input  wire logic signed [15:0] quat_w,
	input  wire logic signed [15:0] quat_x,
	input  wire logic signed [15:0] quat_y,
	input  wire logic signed [15:0] quat_z,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    accepted,
	output logic signed [31:0]      filt_pos_x,
	output logic signed [31:0]      filt_pos_y,
	output logic signed [31:0]      filt_pos_z,
	output logic signed [31:0]      filt_vel_x,
	output logic signed [31:0]      filt_vel_y,
	output logic signed [31:0]      filt_vel_z
);

	dp_cmd_t    cmd;
	dp_status_t status;

	ppvf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	ppvf_dp #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_time_us (sample_time_us),
		.raw_pos_x      (raw_pos_x),
		.raw_pos_y      (raw_pos_y),
		.raw_pos_z      (raw_pos_z),
		.quat_w         (quat_w),
		.quat_x         (quat_x),
		.quat_y         (quat_y),
		.quat_z         (quat_z),
		.cmd            (cmd),
		.status         (status),
		.accepted       (accepted),
		.filt_pos_x     (filt_pos_x),
		.filt_pos_y     (filt_pos_y),
		.filt_pos_z     (filt_pos_z),
		.filt_vel_x     (filt_vel_x),
		.filt_vel_y     (filt_vel_y),
		.filt_vel_z     (filt_vel_z)
	);

endmodule
`default_nettype wire
